// ===== design/particle_pool_update_engine_assert.svh =====
// Assertion macros for the particle pool update engine.
// Included by the top level; depends on nothing else.
`ifndef PARTICLE_POOL_UPDATE_ENGINE_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ppu_pkg.sv =====
// Shared types, widths and helpers of the particle pool update engine.
// No dependencies; used by every module of the block.
package ppu_pkg;

   localparam int POS_W     = 24;
   localparam int LIFE_W    = 16;
   localparam int SIZE_W    = 12;
   localparam int RGB_W     = 24;
   localparam int CAP_W     = 6;
   localparam int CNT_OUT_W = 6;
   localparam int ALPHA_W   = 8;

   localparam int MAX_RESULTS = 32;
   localparam int RES_W       = 6;

   localparam logic [LIFE_W-1:0] FRICTION = 16'd64225;

   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = 43;
   localparam int SUM_W   = 34;

   localparam int DIV_N_W     = 30;
   localparam int DIV_D_W     = 17;
   localparam int Q_W         = 12;
   localparam int SIZE_STEPS  = 12;
   localparam int ALPHA_STEPS = 8;
   localparam int STEP_CNT_W  = 4;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_DRAW  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] vx;
      logic signed [POS_W-1:0] vy;
      logic [LIFE_W-1:0]       left;
      logic [LIFE_W-1:0]       full;
      logic [SIZE_W-1:0]       radius;
      logic [RGB_W-1:0]        tint;
   } entry_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] vel_x;
      logic signed [POS_W-1:0] vel_y;
      logic [LIFE_W-1:0]       life;
      logic [SIZE_W-1:0]       size;
      logic [RGB_W-1:0]        rgb;
      logic [LIFE_W-1:0]       step_time;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [SIZE_W-1:0]       size;
      logic [ALPHA_W-1:0]      alpha;
      logic [RGB_W-1:0]        rgb;
      logic                    has;
      logic [CNT_OUT_W-1:0]    count;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic               alpha_mode;
      logic [DIV_N_W-1:0] num;
      logic [DIV_D_W-1:0] den;
   } div_req_type;

   function automatic logic signed [POS_W-1:0] sat24(logic signed [SUM_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > SUM_W'(signed'(24'sh7fffff))) begin
         r = 24'sh7fffff;
      end else if (v < SUM_W'(signed'(24'sh800000))) begin
         r = 24'sh800000;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/ppu_store.sv =====
// Particle store: one write port and one registered read port.
// Depends on ppu_pkg for the entry layout.
module ppu_store #(
   parameter int AW = 6
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  ppu_pkg::entry_type   wdata,
   input  logic [AW-1:0]        raddr,
   output ppu_pkg::entry_type   rdata_ff
);

   localparam int DEPTH = 2 ** AW;

   ppu_pkg::entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

endmodule

// ===== design/ppu_div.sv =====
// Restoring divider, one quotient bit per cycle, for radius and alpha.
// Depends on ppu_pkg for widths and the request struct.
module ppu_div (
   input  logic                      clock,
   input  logic                      reset,
   input  ppu_pkg::div_req_type      div_req,
   output logic                      busy,
   output logic [ppu_pkg::Q_W-1:0]   quot
);

   logic                             busy_ff, busy_in;
   logic [ppu_pkg::STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ppu_pkg::DIV_N_W-1:0]      rem_ff, rem_in;
   logic [ppu_pkg::DIV_N_W-1:0]      dsh_ff, dsh_in;
   logic [ppu_pkg::Q_W-1:0]          q_ff, q_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         rem_in  = div_req.num;
         q_in    = '0;
         if (div_req.alpha_mode) begin
            dsh_in = ppu_pkg::DIV_N_W'(div_req.den) << (ppu_pkg::ALPHA_STEPS - 1);
            cnt_in = ppu_pkg::STEP_CNT_W'(ppu_pkg::ALPHA_STEPS);
         end else begin
            dsh_in = ppu_pkg::DIV_N_W'(div_req.den) << (ppu_pkg::SIZE_STEPS - 1);
            cnt_in = ppu_pkg::STEP_CNT_W'(ppu_pkg::SIZE_STEPS);
         end
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[ppu_pkg::Q_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[ppu_pkg::Q_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ppu_pkg::STEP_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;

endmodule

// ===== design/particle_pool_update_engine.sv =====
// Top level of the particle pool update engine: sequencer, shared multiplier,
// ring bookkeeping and result register. Depends on ppu_pkg, ppu_store, ppu_div
// and the assertion macro header.
//
//   Channel | Ports        | Moves
//   --------+--------------+---------------------------------------------
//   input   | req_*        | one request: add, tick, draw or clear
//   output  | rsp_*        | result items, last marks the final one
//   config  | csr_wr_*     | capacity_limit register
//
// Add writes one entry and clear empties the pool, each plus delivery. A tick reads
// every stored particle and uses the one multiplier four times for each survivor;
// a draw uses it once and the one-bit-per-cycle divider twice for each live
// particle. Reset is synchronous and empties the pool.
// The sequencer holds in its emit and finish states while the result register is full and not taken.
`include "particle_pool_update_engine_assert.svh"

module particle_pool_update_engine #(
   parameter int MAX_PARTICLES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic signed [ppu_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [ppu_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [ppu_pkg::POS_W-1:0]    req_vel_x,
   input  logic signed [ppu_pkg::POS_W-1:0]    req_vel_y,
   input  logic [ppu_pkg::LIFE_W-1:0]          req_life,
   input  logic [ppu_pkg::SIZE_W-1:0]          req_size_in,
   input  logic [ppu_pkg::RGB_W-1:0]           req_rgb_in,
   input  logic [ppu_pkg::LIFE_W-1:0]          req_step_time,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ppu_pkg::POS_W-1:0]    rsp_draw_x,
   output logic signed [ppu_pkg::POS_W-1:0]    rsp_draw_y,
   output logic [ppu_pkg::SIZE_W-1:0]          rsp_draw_size,
   output logic [ppu_pkg::ALPHA_W-1:0]         rsp_draw_alpha,
   output logic [ppu_pkg::RGB_W-1:0]           rsp_draw_rgb,
   output logic                                rsp_has_particle,
   output logic [ppu_pkg::CNT_OUT_W-1:0]       rsp_live_count,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [ppu_pkg::CAP_W-1:0]           csr_wr_data
);

   localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CW = $clog2(MAX_PARTICLES + 1);
   localparam int AW = IW + 1;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_ADD   = 16'h0002,
      S_TRD   = 16'h0004,
      S_TCHK  = 16'h0008,
      S_TMUL  = 16'h0010,
      S_TWR   = 16'h0020,
      S_TEND  = 16'h0040,
      S_DRD   = 16'h0080,
      S_DCHK  = 16'h0100,
      S_DMUL  = 16'h0200,
      S_DSZ   = 16'h0400,
      S_WSZ   = 16'h0800,
      S_DAL   = 16'h1000,
      S_WAL   = 16'h2000,
      S_DEMIT = 16'h4000,
      S_FIN   = 16'h8000
   } state_type;

   state_type                            state_ff, state_in;
   ppu_pkg::req_type                     req_ff, req_in;
   logic [ppu_pkg::CAP_W-1:0]            cap_ff, cap_in;
   logic                                 bank_ff, bank_in;
   logic [IW-1:0]                        oldest_ff, oldest_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [CW-1:0]                        idx_ff, idx_in;
   logic [CW-1:0]                        wr_ff, wr_in;
   logic [ppu_pkg::RES_W-1:0]            found_ff, found_in;
   logic [2:0]                           mstep_ff, mstep_in;
   logic signed [ppu_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ppu_pkg::POS_W-1:0]     nx_ff, nx_in, ny_ff, ny_in;
   logic signed [ppu_pkg::POS_W-1:0]     nvx_ff, nvx_in, nvy_ff, nvy_in;
   logic [ppu_pkg::SIZE_W-1:0]           size_ff, size_in;
   ppu_pkg::rsp_type                     pend_ff, pend_in;
   logic                                 pend_valid_ff, pend_valid_in;
   ppu_pkg::rsp_type                     rsp_ff, rsp_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   logic                                 st_we;
   logic [AW-1:0]                        st_waddr;
   ppu_pkg::entry_type                   st_wdata;
   logic [AW-1:0]                        st_raddr;
   ppu_pkg::entry_type                   rd;

   ppu_pkg::div_req_type                 div_req;
   logic                                 div_busy;
   logic [ppu_pkg::Q_W-1:0]              div_q;

   logic signed [ppu_pkg::MUL_A_W-1:0]   mul_a;
   logic [ppu_pkg::MUL_B_W-1:0]          mul_b;
   logic signed [ppu_pkg::PROD_W-1:0]    prod;
   logic signed [ppu_pkg::SUM_W-1:0]     pos_sum;
   logic signed [ppu_pkg::POS_W-1:0]     pos_base;

   logic                                 out_free;
   logic [6:0]                           cap_eff;
   logic                                 evict;
   logic [IW-1:0]                        add_oldest;
   logic [CW-1:0]                        add_count;
   logic [CW-1:0]                        idx_next;
   logic                                 idx_end;
   ppu_pkg::rsp_type                     empty_rsp;

   function automatic logic [IW-1:0] ring_slot(logic [IW-1:0] base, logic [CW-1:0] ofs);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(ofs);
      if (sum >= (CW+1)'(MAX_PARTICLES)) begin
         sum = sum - (CW+1)'(MAX_PARTICLES);
      end
      return sum[IW-1:0];
   endfunction

   ppu_store #(.AW(AW)) u_store (
      .clock    (clock),
      .we       (st_we),
      .waddr    (st_waddr),
      .wdata    (st_wdata),
      .raddr    (st_raddr),
      .rdata_ff (rd)
   );

   ppu_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .busy    (div_busy),
      .quot    (div_q)
   );

   assign st_raddr = {bank_ff, ring_slot(oldest_ff, idx_ff)};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign idx_next = CW'(idx_ff + 1'b1);
   assign idx_end  = (idx_next == count_ff);

   // A capacity of zero acts as one; above the pool depth it acts as the depth.
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = 7'd1;
      end else if (7'(cap_ff) > 7'(MAX_PARTICLES)) begin
         cap_eff = 7'(MAX_PARTICLES);
      end else begin
         cap_eff = 7'(cap_ff);
      end
      evict      = (7'(count_ff) >= cap_eff) && (count_ff != '0);
      add_oldest = evict ? ring_slot(oldest_ff, CW'(1)) : oldest_ff;
      add_count  = evict ? CW'(count_ff - 1'b1) : count_ff;
   end

   // Shared multiplier operand selection.
   always_comb begin
      if (state_ff == S_DMUL) begin
         mul_a = ppu_pkg::MUL_A_W'(rd.radius);
         mul_b = ppu_pkg::MUL_B_W'(rd.full) + ppu_pkg::MUL_B_W'(rd.left);
      end else begin
         unique case (mstep_ff[1:0])
            2'd0: begin
               mul_a = ppu_pkg::MUL_A_W'(rd.vx);
               mul_b = ppu_pkg::MUL_B_W'(req_ff.step_time);
            end
            2'd1: begin
               mul_a = ppu_pkg::MUL_A_W'(rd.vy);
               mul_b = ppu_pkg::MUL_B_W'(req_ff.step_time);
            end
            2'd2: begin
               mul_a = ppu_pkg::MUL_A_W'(rd.vx);
               mul_b = ppu_pkg::MUL_B_W'(ppu_pkg::FRICTION);
            end
            default: begin
               mul_a = ppu_pkg::MUL_A_W'(rd.vy);
               mul_b = ppu_pkg::MUL_B_W'(ppu_pkg::FRICTION);
            end
         endcase
      end
      prod = ppu_pkg::PROD_W'(mul_a * $signed({1'b0, mul_b}));
      pos_base = (mstep_ff == 3'd1) ? rd.x : rd.y;
      pos_sum  = ppu_pkg::SUM_W'(pos_base) + ppu_pkg::SUM_W'(prod_ff >>> 10);
   end

   always_comb begin
      empty_rsp       = '0;
      empty_rsp.count = ppu_pkg::CNT_OUT_W'(count_ff);
      empty_rsp.last  = 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      bank_in       = bank_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      found_in      = found_ff;
      mstep_in      = mstep_ff;
      prod_in       = prod_ff;
      nx_in         = nx_ff;
      ny_in         = ny_ff;
      nvx_in        = nvx_ff;
      nvy_in        = nvy_ff;
      size_in       = size_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      st_we         = 1'b0;
      st_waddr      = {~bank_ff, wr_ff[IW-1:0]};
      st_wdata      = rd;
      div_req       = '0;
      div_req.num   = prod_ff[ppu_pkg::DIV_N_W-1:0];
      div_req.den   = {rd.full, 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = {req_kind, req_pos_x, req_pos_y, req_vel_x, req_vel_y,
                         req_life, req_size_in, req_rgb_in, req_step_time};
               idx_in   = '0;
               wr_in    = '0;
               found_in = '0;
               unique case (req_kind)
                  ppu_pkg::KIND_ADD:  state_in = S_ADD;
                  ppu_pkg::KIND_TICK: state_in = (count_ff == '0) ? S_TEND : S_TRD;
                  ppu_pkg::KIND_DRAW: state_in = (count_ff == '0) ? S_FIN : S_DRD;
                  default: begin
                     count_in  = '0;
                     oldest_in = '0;
                     state_in  = S_FIN;
                  end
               endcase
            end
         end
         S_ADD: begin
            st_we    = 1'b1;
            st_waddr = {bank_ff, ring_slot(add_oldest, add_count)};
            st_wdata = {req_ff.pos_x, req_ff.pos_y, req_ff.vel_x, req_ff.vel_y,
                        req_ff.life, req_ff.life, req_ff.size, req_ff.rgb};
            oldest_in = add_oldest;
            count_in  = CW'(add_count + 1'b1);
            state_in  = S_FIN;
         end
         S_TRD: begin
            state_in = S_TCHK;
         end
         S_TCHK: begin
            if (rd.left <= req_ff.step_time) begin
               idx_in   = idx_next;
               state_in = idx_end ? S_TEND : S_TRD;
            end else begin
               mstep_in = '0;
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            if (mstep_ff != 3'd4) begin
               prod_in = prod;
            end
            // The product of the previous step is registered and folded in during the next step.
            unique case (mstep_ff)
               3'd1:    nx_in  = ppu_pkg::sat24(pos_sum);
               3'd2:    ny_in  = ppu_pkg::sat24(pos_sum);
               3'd3:    nvx_in = ppu_pkg::POS_W'(prod_ff >>> 16);
               3'd4:    nvy_in = ppu_pkg::POS_W'(prod_ff >>> 16);
               default: ;
            endcase
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 3'd4) begin
               state_in = S_TWR;
            end
         end
         S_TWR: begin
            st_we    = 1'b1;
            st_wdata = {nx_ff, ny_ff, nvx_ff, nvy_ff, rd.left - req_ff.step_time,
                        rd.full, rd.radius, rd.tint};
            wr_in    = CW'(wr_ff + 1'b1);
            idx_in   = idx_next;
            state_in = idx_end ? S_TEND : S_TRD;
         end
         S_TEND: begin
            // Survivors now sit from slot zero of the other bank.
            bank_in   = ~bank_ff;
            oldest_in = '0;
            count_in  = wr_ff;
            state_in  = S_FIN;
         end
         S_DRD: begin
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if (rd.left == '0) begin
               idx_in   = idx_next;
               state_in = idx_end ? S_FIN : S_DRD;
            end else begin
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            prod_in  = prod;
            state_in = S_DSZ;
         end
         S_DSZ: begin
            div_req.start = 1'b1;
            state_in      = S_WSZ;
         end
         S_WSZ: begin
            if (!div_busy) begin
               size_in  = div_q;
               state_in = S_DAL;
            end
         end
         S_DAL: begin
            div_req.start      = 1'b1;
            div_req.alpha_mode = 1'b1;
            div_req.num        = ppu_pkg::DIV_N_W'({rd.left, 8'd0}) -
                                 ppu_pkg::DIV_N_W'(rd.left);
            div_req.den        = ppu_pkg::DIV_D_W'(rd.full);
            state_in           = S_WAL;
         end
         S_WAL: begin
            if (!div_busy) begin
               state_in = S_DEMIT;
            end
         end
         S_DEMIT: begin
            // The previous particle goes out only once a later one is known.
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_in       = pend_ff;
                  rsp_valid_in = 1'b1;
               end
               pend_in.x     = rd.x;
               pend_in.y     = rd.y;
               pend_in.size  = size_ff;
               pend_in.alpha = div_q[ppu_pkg::ALPHA_W-1:0];
               pend_in.rgb   = rd.tint;
               pend_in.has   = 1'b1;
               pend_in.count = ppu_pkg::CNT_OUT_W'(count_ff);
               pend_in.last  = 1'b0;
               pend_valid_in = 1'b1;
               found_in      = ppu_pkg::RES_W'(found_ff + 1'b1);
               idx_in        = idx_next;
               if (idx_end ||
                   ppu_pkg::RES_W'(found_ff + 1'b1) ==
                   ppu_pkg::RES_W'(ppu_pkg::MAX_RESULTS)) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_DRD;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               if (pend_valid_ff) begin
                  rsp_in      = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = empty_rsp;
               end
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cap_ff        <= ppu_pkg::CAP_W'(32);
         bank_ff       <= 1'b0;
         oldest_ff     <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         wr_ff         <= '0;
         found_ff      <= '0;
         mstep_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         bank_ff       <= bank_in;
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         wr_ff         <= wr_in;
         found_ff      <= found_in;
         mstep_ff      <= mstep_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      prod_ff <= prod_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      nvx_ff  <= nvx_in;
      nvy_ff  <= nvy_in;
      size_ff <= size_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_draw_x       = rsp_ff.x;
   assign rsp_draw_y       = rsp_ff.y;
   assign rsp_draw_size    = rsp_ff.size;
   assign rsp_draw_alpha   = rsp_ff.alpha;
   assign rsp_draw_rgb     = rsp_ff.rgb;
   assign rsp_has_particle = rsp_ff.has;
   assign rsp_live_count   = rsp_ff.count;
   assign rsp_last         = rsp_ff.last;

   `PPU_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= CW'(MAX_PARTICLES), "particle count exceeds pool depth")
   `PPU_ASSERT_IMP(a_div_free, clock, reset, state_ff == S_DSZ || state_ff == S_DAL,
      !div_busy, "divider started while busy")
   `PPU_ASSERT_NXT(a_tick_rebase, clock, reset, state_ff == S_TEND,
      oldest_ff == '0 && bank_ff != $past(bank_ff), "tick did not rebase the ring")
   `PPU_ASSERT_IMP(a_found_bound, clock, reset, 1'b1,
      found_ff <= ppu_pkg::RES_W'(ppu_pkg::MAX_RESULTS), "draw emitted too many results")

endmodule
